### rtl/chip8ie_pkg.sv
// Shared constants, codes and a helper function of the CHIP-8 execute core.
package chip8ie_pkg;

   localparam int RAM_BYTES     = 4096;
   localparam int RAM_AW        = $clog2(RAM_BYTES);
   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 32;
   localparam int ROW_AW        = $clog2(SCREEN_HEIGHT);
   localparam int COL_W         = $clog2(SCREEN_WIDTH);
   localparam int STACK_DEPTH   = 16;
   localparam int SP_W          = $clog2(STACK_DEPTH);
   localparam int REQ_DATA_W    = 64;
   localparam int RSP_DATA_W    = 80;

   typedef enum logic [1:0] {
      REQ_EXEC  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_TICK  = 2'd2,
      REQ_ROW   = 2'd3
   } req_kind_type;

   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;
   localparam logic [7:0]  FN_SKP   = 8'h9E;
   localparam logic [7:0]  FN_SKNP  = 8'hA1;
   localparam logic [7:0]  FN_LDDT  = 8'h07;
   localparam logic [7:0]  FN_LDK   = 8'h0A;
   localparam logic [7:0]  FN_SETDT = 8'h15;
   localparam logic [7:0]  FN_SETST = 8'h18;
   localparam logic [7:0]  FN_ADDI  = 8'h1E;
   localparam logic [7:0]  FN_FONT  = 8'h29;
   localparam logic [7:0]  FN_BCD   = 8'h33;
   localparam logic [7:0]  FN_STORE = 8'h55;
   localparam logic [7:0]  FN_LOAD  = 8'h65;

   localparam logic [3:0] ALU_LD   = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   typedef enum logic [14:0] {
      ST_IDLE = 15'b000000000000001,
      ST_FRD  = 15'b000000000000010,
      ST_RDX  = 15'b000000000000100,
      ST_EXE  = 15'b000000000001000,
      ST_RET  = 15'b000000000010000,
      ST_BCD  = 15'b000000000100000,
      ST_SRD  = 15'b000000001000000,
      ST_SWR  = 15'b000000010000000,
      ST_LRD  = 15'b000000100000000,
      ST_LWR  = 15'b000001000000000,
      ST_DRA  = 15'b000010000000000,
      ST_DRF  = 15'b000100000000000,
      ST_DWF  = 15'b001000000000000,
      ST_VFW  = 15'b010000000000000,
      ST_DONE = 15'b100000000000000
   } state_type;

   // Tens digit of a value below 100: multiply by 205/2048.
   function automatic logic [3:0] bcd_tens(input logic [6:0] rem);
      logic [14:0] prod;
      prod = 15'(rem) * 15'd205;
      return prod[14:11];
   endfunction

endpackage

### rtl/chip8_instruction_execute.sv
// CHIP-8 instruction execute core: sequencer around register, stack, ram and frame memories.
// Each memory has a single read port; DRW, BCD and Fx55/Fx65 step through their bytes one at a time.
// Throughput: one item at a time; the next beat is taken as soon as the sequencer is idle.
// Reset (synchronous, active high) zeroes V0-VF, I, SP and timers, clears the frame, pc = 0x200.
module chip8_instruction_execute
   import chip8ie_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // opcode[15:0], random_byte[23:16], keys_down[39:24], addr[51:40], wdata[59:52], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // next_pc[11:0], display_row[75:12], bad_opcode[76], sound_on[77], key_wait[78], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Sequencer and architectural registers.
   state_type         state_ff, state_in;
   logic [15:0]       op_ff, op_in;
   logic [7:0]        rnd_ff, rnd_in;
   logic [15:0]       keys_ff, keys_in;
   logic [11:0]       addr_ff, addr_in;
   logic [11:0]       pc_ff, pc_in;
   logic [11:0]       idx_ff, idx_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [7:0]        dt_ff, dt_in;
   logic [7:0]        snd_ff, snd_in;
   logic [7:0]        vx_ff, vx_in;
   logic [7:0]        vy_ff, vy_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic              hit_ff, hit_in;
   logic [7:0]        flag_ff, flag_in;
   logic [3:0]        dh_ff, dh_in, dt10_ff, dt10_in, do_ff, do_in;
   logic [7:0]        sprite_ff, sprite_in;
   logic              bad_ff, bad_in;
   logic              wait_ff, wait_in;
   logic [63:0]       row_ff, row_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [15:0]       vvalid_ff;
   logic [SCREEN_HEIGHT-1:0] fvalid_ff;

   // Memories and their registered read data.
   logic [7:0]        vreg_mem [16];
   logic [7:0]        ram_mem [RAM_BYTES];
   logic [11:0]       stk_mem [STACK_DEPTH];
   logic [63:0]       frame_mem [SCREEN_HEIGHT];
   logic [7:0]        vr_q_ff, ram_q_ff;
   logic              vr_qv_ff, fr_qv_ff;
   logic [11:0]       stk_q_ff;
   logic [63:0]       fr_q_ff;

   // Memory port controls.
   logic [3:0]        vr_raddr, vr_waddr;
   logic              vr_we;
   logic [7:0]        vr_wdata;
   logic [RAM_AW-1:0] ram_raddr, ram_waddr;
   logic              ram_we;
   logic [7:0]        ram_wdata;
   logic [SP_W-1:0]   stk_raddr;
   logic              stk_we;
   logic [ROW_AW-1:0] fr_raddr, fr_row;
   logic              fr_we, fv_clear;
   logic [63:0]       fr_wdata;

   // Decoded fields and helpers.
   logic [3:0]        op_hi, op_x, op_y, op_n;
   logic [7:0]        op_kk;
   logic [11:0]       op_nnn;
   logic [7:0]        vr_data;
   logic [63:0]       fr_data;
   logic [RAM_AW-1:0] ram_off;
   logic [63:0]       spr_word, spr_mask;
   logic [127:0]      spr_dbl;
   logic              out_load;

   assign op_hi  = op_ff[15:12];
   assign op_x   = op_ff[11:8];
   assign op_y   = op_ff[7:4];
   assign op_n   = op_ff[3:0];
   assign op_kk  = op_ff[7:0];
   assign op_nnn = op_ff[11:0];

   // Entries never written read as zero through the valid bits.
   assign vr_data = vr_qv_ff ? vr_q_ff : 8'd0;
   assign fr_data = fr_qv_ff ? fr_q_ff : 64'd0;
   assign ram_off = RAM_AW'(idx_ff + {8'd0, cnt_ff});
   assign fr_row  = ROW_AW'(vy_ff[ROW_AW-1:0] + ROW_AW'(cnt_ff));

   // Sprite byte rotated so its bit 7 lands on column vx_ff mod 64, wrapping at the right edge.
   assign spr_word = {sprite_ff, 56'd0};
   assign spr_dbl  = {spr_word, spr_word} >> vx_ff[COL_W-1:0];
   assign spr_mask = spr_dbl[63:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      logic [8:0]  sum;
      logic [7:0]  flg, vxe, vye, res, rem;
      logic [3:0]  hund, tens, kidx;
      logic        pressed;

      state_in  = state_ff;
      op_in     = op_ff;
      rnd_in    = rnd_ff;
      keys_in   = keys_ff;
      addr_in   = addr_ff;
      pc_in     = pc_ff;
      idx_in    = idx_ff;
      sp_in     = sp_ff;
      dt_in     = dt_ff;
      snd_in    = snd_ff;
      vx_in     = vx_ff;
      vy_in     = vy_ff;
      cnt_in    = cnt_ff;
      hit_in    = hit_ff;
      flag_in   = flag_ff;
      dh_in     = dh_ff;
      dt10_in   = dt10_ff;
      do_in     = do_ff;
      sprite_in = sprite_ff;
      bad_in    = bad_ff;
      wait_in   = wait_ff;
      row_in    = row_ff;

      vr_raddr  = cnt_ff;
      vr_we     = 1'b0;
      vr_waddr  = op_x;
      vr_wdata  = 8'd0;
      ram_raddr = ram_off;
      ram_we    = 1'b0;
      ram_waddr = ram_off;
      ram_wdata = 8'd0;
      stk_raddr = sp_ff;
      stk_we    = 1'b0;
      fr_raddr  = fr_row;
      fr_we     = 1'b0;
      fr_wdata  = fr_data ^ spr_mask;
      fv_clear  = 1'b0;

      sum     = {1'b0, vx_ff} + {1'b0, vr_data};
      flg     = 8'd0;
      vxe     = vx_ff;
      vye     = vr_data;
      res     = 8'd0;
      hund    = (vx_ff >= 8'd200) ? 4'd2 : ((vx_ff >= 8'd100) ? 4'd1 : 4'd0);
      rem     = vx_ff - 8'(hund * 8'd100);
      tens    = bcd_tens(rem[6:0]);
      pressed = (vx_ff[7:4] == 4'd0) && keys_ff[vx_ff[3:0]];
      kidx    = 4'd0;
      for (int k = 15; k >= 0; k--) begin
         if (keys_ff[k]) kidx = 4'(k);
      end

      case (state_ff)
         ST_IDLE: begin
            vr_raddr = (req_tdata[15:12] == 4'hB) ? 4'd0 : req_tdata[11:8];
            fr_raddr = req_tdata[40 +: ROW_AW];
            if (req_tvalid) begin
               op_in   = req_tdata[15:0];
               rnd_in  = req_tdata[23:16];
               keys_in = req_tdata[39:24];
               addr_in = req_tdata[51:40];
               bad_in  = 1'b0;
               wait_in = 1'b0;
               row_in  = 64'd0;
               case (req_tuser)
                  REQ_EXEC: begin
                     pc_in    = pc_ff + 12'd2;
                     state_in = ST_RDX;
                  end
                  REQ_WRITE: begin
                     ram_we    = 1'b1;
                     ram_waddr = req_tdata[51:40];
                     ram_wdata = req_tdata[59:52];
                     state_in  = ST_DONE;
                  end
                  REQ_TICK: begin
                     if (dt_ff != 8'd0) dt_in = dt_ff - 8'd1;
                     if (snd_ff != 8'd0) snd_in = snd_ff - 8'd1;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_FRD;
                  end
               endcase
            end
         end
         ST_FRD: begin
            row_in   = (addr_ff < 12'(SCREEN_HEIGHT)) ? fr_data : 64'd0;
            state_in = ST_DONE;
         end
         ST_RDX: begin
            vx_in    = vr_data;
            vr_raddr = op_y;
            state_in = ST_EXE;
         end
         ST_EXE: begin
            vy_in    = vr_data;
            state_in = ST_DONE;
            case (op_hi)
               4'h0: begin
                  if (op_ff == OP_CLS) begin
                     fv_clear = 1'b1;
                  end else if (op_ff == OP_RET) begin
                     sp_in     = (sp_ff == '0) ? SP_W'(STACK_DEPTH - 1) : sp_ff - 1'b1;
                     stk_raddr = sp_in;
                     state_in  = ST_RET;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               4'h1: pc_in = op_nnn;
               4'h2: begin
                  stk_we = 1'b1;
                  sp_in  = (sp_ff == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_ff + 1'b1;
                  pc_in  = op_nnn;
               end
               4'h3: if (vx_ff == op_kk) pc_in = pc_ff + 12'd2;
               4'h4: if (vx_ff != op_kk) pc_in = pc_ff + 12'd2;
               4'h5: begin
                  if (op_n != 4'h0) bad_in = 1'b1;
                  else if (vx_ff == vr_data) pc_in = pc_ff + 12'd2;
               end
               4'h6: begin
                  vr_we    = 1'b1;
                  vr_wdata = op_kk;
               end
               4'h7: begin
                  vr_we    = 1'b1;
                  vr_wdata = vx_ff + op_kk;
               end
               4'h8: begin
                  case (op_n)
                     ALU_LD, ALU_OR, ALU_AND, ALU_XOR: begin
                        vr_we = 1'b1;
                        case (op_n)
                           ALU_LD:  vr_wdata = vr_data;
                           ALU_OR:  vr_wdata = vx_ff | vr_data;
                           ALU_AND: vr_wdata = vx_ff & vr_data;
                           default: vr_wdata = vx_ff ^ vr_data;
                        endcase
                     end
                     ALU_ADD: begin
                        // Vx first, then the carry lands in VF.
                        vr_we    = 1'b1;
                        vr_wdata = sum[7:0];
                        flag_in  = {7'd0, sum[8]};
                        state_in = ST_VFW;
                     end
                     ALU_SUB, ALU_SUBN, ALU_SHR, ALU_SHL: begin
                        // Operands that are VF see the flag; VF is written after Vx unless x is F.
                        case (op_n)
                           ALU_SUB:  flg = {7'd0, vx_ff > vr_data};
                           ALU_SUBN: flg = {7'd0, vx_ff < vr_data};
                           ALU_SHR:  flg = {7'd0, vx_ff[0]};
                           default:  flg = {7'd0, vx_ff[7]};
                        endcase
                        vxe = (op_x == 4'hF) ? flg : vx_ff;
                        vye = (op_y == 4'hF) ? flg : vr_data;
                        case (op_n)
                           ALU_SUB:  res = vxe - vye;
                           ALU_SUBN: res = vye - vxe;
                           ALU_SHR:  res = vxe >> 1;
                           default:  res = vxe << 1;
                        endcase
                        vr_we    = 1'b1;
                        vr_wdata = res;
                        flag_in  = flg;
                        if (op_x != 4'hF) state_in = ST_VFW;
                     end
                     default: bad_in = 1'b1;
                  endcase
               end
               4'h9: begin
                  if (op_n != 4'h0) bad_in = 1'b1;
                  else if (vx_ff != vr_data) pc_in = pc_ff + 12'd2;
               end
               4'hA: idx_in = op_nnn;
               4'hB: pc_in = op_nnn + {4'd0, vx_ff};
               4'hC: begin
                  vr_we    = 1'b1;
                  vr_wdata = rnd_ff & op_kk;
               end
               4'hD: begin
                  cnt_in = 4'd0;
                  hit_in = 1'b0;
                  if (op_n == 4'd0) begin
                     flag_in  = 8'd0;
                     state_in = ST_VFW;
                  end else begin
                     state_in = ST_DRA;
                  end
               end
               4'hE: begin
                  if (op_kk == FN_SKP) begin
                     if (pressed) pc_in = pc_ff + 12'd2;
                  end else if (op_kk == FN_SKNP) begin
                     if (!pressed) pc_in = pc_ff + 12'd2;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               default: begin
                  case (op_kk)
                     FN_LDDT: begin
                        vr_we    = 1'b1;
                        vr_wdata = dt_ff;
                     end
                     FN_LDK: begin
                        if (keys_ff == 16'd0) begin
                           pc_in   = pc_ff - 12'd2;
                           wait_in = 1'b1;
                        end else begin
                           vr_we    = 1'b1;
                           vr_wdata = {4'd0, kidx};
                        end
                     end
                     FN_SETDT: dt_in  = vx_ff;
                     FN_SETST: snd_in = vx_ff;
                     FN_ADDI:  idx_in = idx_ff + {4'd0, vx_ff};
                     FN_FONT:  idx_in = {2'b00, vx_ff, 2'b00} + {4'd0, vx_ff};
                     FN_BCD: begin
                        dh_in    = hund;
                        dt10_in  = tens;
                        do_in    = 4'(rem - 8'(tens * 8'd10));
                        cnt_in   = 4'd0;
                        state_in = ST_BCD;
                     end
                     FN_STORE: begin
                        cnt_in   = 4'd0;
                        state_in = ST_SRD;
                     end
                     FN_LOAD: begin
                        cnt_in   = 4'd0;
                        state_in = ST_LRD;
                     end
                     default: bad_in = 1'b1;
                  endcase
               end
            endcase
         end
         ST_RET: begin
            pc_in    = stk_q_ff;
            state_in = ST_DONE;
         end
         ST_BCD: begin
            ram_we = 1'b1;
            case (cnt_ff[1:0])
               2'd0:    ram_wdata = {4'd0, dh_ff};
               2'd1:    ram_wdata = {4'd0, dt10_ff};
               default: ram_wdata = {4'd0, do_ff};
            endcase
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd2) state_in = ST_DONE;
         end
         ST_SRD: state_in = ST_SWR;
         ST_SWR: begin
            ram_we    = 1'b1;
            ram_wdata = vr_data;
            cnt_in    = cnt_ff + 4'd1;
            state_in  = (cnt_ff == op_x) ? ST_DONE : ST_SRD;
         end
         ST_LRD: state_in = ST_LWR;
         ST_LWR: begin
            vr_we    = 1'b1;
            vr_waddr = cnt_ff;
            vr_wdata = ram_q_ff;
            cnt_in   = cnt_ff + 4'd1;
            state_in = (cnt_ff == op_x) ? ST_DONE : ST_LRD;
         end
         ST_DRA: state_in = ST_DRF;
         ST_DRF: begin
            sprite_in = ram_q_ff;
            state_in  = ST_DWF;
         end
         ST_DWF: begin
            fr_we  = 1'b1;
            hit_in = hit_ff | (|(fr_data & spr_mask));
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == op_n - 4'd1) begin
               flag_in  = {7'd0, hit_in};
               state_in = ST_VFW;
            end else begin
               state_in = ST_DRA;
            end
         end
         ST_VFW: begin
            vr_we    = 1'b1;
            vr_waddr = 4'hF;
            vr_wdata = flag_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result register: the next item is taken while a finished beat still waits.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, wait_ff, snd_ff != 8'd0, bad_ff, row_ff, pc_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= 12'h200;
         idx_ff       <= 12'd0;
         sp_ff        <= '0;
         dt_ff        <= 8'd0;
         snd_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
         vvalid_ff    <= 16'd0;
         fvalid_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         idx_ff       <= idx_in;
         sp_ff        <= sp_in;
         dt_ff        <= dt_in;
         snd_ff       <= snd_in;
         rsp_valid_ff <= rsp_valid_in;
         if (vr_we) vvalid_ff[vr_waddr] <= 1'b1;
         if (fv_clear) fvalid_ff <= '0;
         else if (fr_we) fvalid_ff[fr_row] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      rnd_ff      <= rnd_in;
      keys_ff     <= keys_in;
      addr_ff     <= addr_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      cnt_ff      <= cnt_in;
      hit_ff      <= hit_in;
      flag_ff     <= flag_in;
      dh_ff       <= dh_in;
      dt10_ff     <= dt10_in;
      do_ff       <= do_in;
      sprite_ff   <= sprite_in;
      bad_ff      <= bad_in;
      wait_ff     <= wait_in;
      row_ff      <= row_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Register file memory.
   always_ff @(posedge clock) begin
      if (vr_we) vreg_mem[vr_waddr] <= vr_wdata;
      vr_q_ff  <= vreg_mem[vr_raddr];
      vr_qv_ff <= vvalid_ff[vr_raddr];
   end

   // Program ram.
   always_ff @(posedge clock) begin
      if (ram_we) ram_mem[ram_waddr] <= ram_wdata;
      ram_q_ff <= ram_mem[ram_raddr];
   end

   // Call stack.
   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[sp_ff] <= pc_ff;
      stk_q_ff <= stk_mem[stk_raddr];
   end

   // Frame buffer, one 64-pixel row per entry.
   always_ff @(posedge clock) begin
      if (fr_we) frame_mem[fr_row] <= fr_wdata;
      fr_q_ff  <= frame_mem[fr_raddr];
      fr_qv_ff <= fvalid_ff[fr_raddr];
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("core took a beat while still busy");

   a_frame_cleared: assert property (@(posedge clock)
      reset |=> (fvalid_ff == '0) && (vvalid_ff == 16'd0))
      else $error("valid bits not cleared by reset");

   a_store_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWR || state_ff == ST_LWR) |-> (cnt_ff <= op_x))
      else $error("block transfer ran past Vx");

   a_draw_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DWF) |-> (cnt_ff < op_n))
      else $error("sprite draw ran past its height");

endmodule

### verif/chip8_instruction_execute_tb.sv
// Self-checking testbench for the CHIP-8 instruction execute core.
module chip8_instruction_execute_tb
   import chip8ie_pkg::*;
();

   typedef struct {
      req_kind_type kind;
      logic [15:0]  op;
      logic [7:0]   rnd;
      logic [15:0]  keys;
      logic [11:0]  addr;
      logic [7:0]   wdata;
   } chip_beat_type;

   typedef struct {
      logic [11:0] pc;
      logic [63:0] row;
      logic        bad;
      logic        snd;
      logic        wt;
   } chip_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = REQ_EXEC;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   chip8_instruction_execute dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #2 clock = ~clock;

   // Shadow machine state, advanced as each beat is issued. The core works on one
   // beat at a time and in order, so issue order equals execution order.
   logic [7:0]  vreg [16];
   logic [11:0] ireg, pcreg;
   logic [3:0]  sp;
   logic [11:0] stk [16];
   logic [7:0]  dtimer, stimer;
   logic [7:0]  mem [RAM_BYTES];
   logic [63:0] screen [SCREEN_HEIGHT];
   bit          mem_ok [RAM_BYTES];
   bit          stk_ok [16];

   chip_result_type pending_results [$];
   int           mismatches = 0;
   int           beats_seen = 0;
   bit           stimulus_done = 1'b0;
   bit           quiet_sender = 1'b0;
   bit           quiet_receiver = 1'b0;

   function automatic chip_result_type chip_predict(chip_beat_type b);
      chip_result_type r;
      logic [3:0]  x, y, n;
      logic [7:0]  kk, bits;
      logic [8:0]  sum;
      logic [11:0] a;
      logic [4:0]  row;
      logic [5:0]  col;
      bit          hit, f;
      r = '{pc: 12'd0, row: 64'd0, bad: 1'b0, snd: 1'b0, wt: 1'b0};
      x = b.op[11:8];
      y = b.op[7:4];
      n = b.op[3:0];
      kk = b.op[7:0];
      case (b.kind)
         REQ_WRITE: begin
            mem[b.addr] = b.wdata;
            mem_ok[b.addr] = 1'b1;
         end
         REQ_TICK: begin
            if (dtimer != 0) dtimer--;
            if (stimer != 0) stimer--;
         end
         REQ_ROW: begin
            if (b.addr < SCREEN_HEIGHT) r.row = screen[b.addr[4:0]];
         end
         default: begin
            pcreg = pcreg + 12'd2;
            if (b.op == OP_CLS) begin
               foreach (screen[i]) screen[i] = '0;
            end else if (b.op == OP_RET) begin
               sp = sp - 4'd1;
               pcreg = stk[sp];
            end else begin
               case (b.op[15:12])
                  4'h1: pcreg = b.op[11:0];
                  4'h2: begin
                     stk[sp] = pcreg;
                     stk_ok[sp] = 1'b1;
                     sp = sp + 4'd1;
                     pcreg = b.op[11:0];
                  end
                  4'h3: if (vreg[x] == kk) pcreg += 12'd2;
                  4'h4: if (vreg[x] != kk) pcreg += 12'd2;
                  4'h5: begin
                     if (n != 0) r.bad = 1'b1;
                     else if (vreg[x] == vreg[y]) pcreg += 12'd2;
                  end
                  4'h6: vreg[x] = kk;
                  4'h7: vreg[x] = vreg[x] + kk;
                  4'h8: begin
                     case (n)
                        ALU_LD:  vreg[x] = vreg[y];
                        ALU_OR:  vreg[x] = vreg[x] | vreg[y];
                        ALU_AND: vreg[x] = vreg[x] & vreg[y];
                        ALU_XOR: vreg[x] = vreg[x] ^ vreg[y];
                        ALU_ADD: begin
                           sum = {1'b0, vreg[x]} + {1'b0, vreg[y]};
                           vreg[x] = sum[7:0];
                           vreg[15] = {7'd0, sum[8]};
                        end
                        // The flag lands first; the difference then uses the updated file.
                        ALU_SUB: begin
                           f = vreg[x] > vreg[y];
                           vreg[15] = {7'd0, f};
                           vreg[x] = vreg[x] - vreg[y];
                        end
                        ALU_SUBN: begin
                           f = vreg[x] < vreg[y];
                           vreg[15] = {7'd0, f};
                           vreg[x] = vreg[y] - vreg[x];
                        end
                        ALU_SHR: begin
                           vreg[15] = {7'd0, vreg[x][0]};
                           vreg[x] = vreg[x] >> 1;
                        end
                        ALU_SHL: begin
                           vreg[15] = {7'd0, vreg[x][7]};
                           vreg[x] = vreg[x] << 1;
                        end
                        default: r.bad = 1'b1;
                     endcase
                  end
                  4'h9: begin
                     if (n != 0) r.bad = 1'b1;
                     else if (vreg[x] != vreg[y]) pcreg += 12'd2;
                  end
                  4'hA: ireg = b.op[11:0];
                  4'hB: pcreg = b.op[11:0] + {4'd0, vreg[0]};
                  4'hC: vreg[x] = b.rnd & kk;
                  4'hD: begin
                     hit = 1'b0;
                     for (int i = 0; i < n; i++) begin
                        a = ireg + 12'(i);
                        bits = mem[a];
                        row = 5'(vreg[y] + i);
                        for (int j = 0; j < 8; j++) begin
                           if (bits[7-j]) begin
                              col = 6'(vreg[x] + j);
                              if (screen[row][63-col]) hit = 1'b1;
                              screen[row][63-col] = ~screen[row][63-col];
                           end
                        end
                     end
                     vreg[15] = {7'd0, hit};
                  end
                  4'hE: begin
                     if (kk == FN_SKP) begin
                        if (vreg[x] < 16 && b.keys[vreg[x][3:0]]) pcreg += 12'd2;
                     end else if (kk == FN_SKNP) begin
                        if (!(vreg[x] < 16 && b.keys[vreg[x][3:0]])) pcreg += 12'd2;
                     end else r.bad = 1'b1;
                  end
                  4'hF: begin
                     case (kk)
                        FN_LDDT:  vreg[x] = dtimer;
                        FN_LDK: begin
                           if (b.keys == 0) begin
                              pcreg = pcreg - 12'd2;
                              r.wt = 1'b1;
                           end else begin
                              for (int k = 15; k >= 0; k--)
                                 if (b.keys[k]) vreg[x] = 8'(k);
                           end
                        end
                        FN_SETDT: dtimer = vreg[x];
                        FN_SETST: stimer = vreg[x];
                        FN_ADDI:  ireg = ireg + {4'd0, vreg[x]};
                        FN_FONT:  ireg = 12'(5 * vreg[x]);
                        FN_BCD: begin
                           for (int i = 0; i < 3; i++) begin
                              a = ireg + 12'(i);
                              mem_ok[a] = 1'b1;
                              case (i)
                                 0: mem[a] = vreg[x] / 100;
                                 1: mem[a] = (vreg[x] / 10) % 10;
                                 default: mem[a] = vreg[x] % 10;
                              endcase
                           end
                        end
                        FN_STORE: begin
                           for (int i = 0; i <= x; i++) begin
                              a = ireg + 12'(i);
                              mem[a] = vreg[i];
                              mem_ok[a] = 1'b1;
                           end
                        end
                        FN_LOAD: begin
                           for (int i = 0; i <= x; i++) vreg[i] = mem[ireg + 12'(i)];
                        end
                        default: r.bad = 1'b1;
                     endcase
                  end
                  default: r.bad = 1'b1;  // leftover 0nnn system calls
               endcase
            end
         end
      endcase
      r.pc = pcreg;
      r.snd = (stimer != 0);
      return r;
   endfunction

   // Returns -1 when the beat touches only defined storage, -2 when a return would pop
   // a stack slot never pushed, or the first ram address read before any write.
   function automatic int undefined_read(chip_beat_type b);
      logic [11:0] a;
      if (b.kind != REQ_EXEC) return -1;
      if (b.op == OP_RET) return stk_ok[sp - 4'd1] ? -1 : -2;
      if (b.op[15:12] == 4'hD) begin
         for (int i = 0; i < b.op[3:0]; i++) begin
            a = ireg + 12'(i);
            if (!mem_ok[a]) return int'(a);
         end
      end
      if (b.op[15:12] == 4'hF && b.op[7:0] == FN_LOAD) begin
         for (int i = 0; i <= b.op[11:8]; i++) begin
            a = ireg + 12'(i);
            if (!mem_ok[a]) return int'(a);
         end
      end
      return -1;
   endfunction

   function automatic chip_beat_type mk_beat(req_kind_type k, logic [15:0] op,
                                             logic [15:0] keys, logic [11:0] addr,
                                             logic [7:0] wdata);
      chip_beat_type b;
      b = '{kind: k, op: op, rnd: 8'hA5, keys: keys, addr: addr, wdata: wdata};
      return b;
   endfunction

   function automatic chip_beat_type random_beat();
      chip_beat_type b;
      int          pick;
      logic [7:0]  f_codes [13];
      logic [3:0]  alu_codes [9];
      f_codes = '{FN_LDDT, FN_LDK, FN_SETDT, FN_SETST, FN_ADDI, FN_FONT, FN_BCD,
                  FN_STORE, FN_LOAD, FN_LOAD, FN_STORE, FN_SETST, FN_SETDT};
      alu_codes = '{ALU_LD, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
                    ALU_SUBN, ALU_SHL};
      b.op = 16'($urandom);
      b.rnd = 8'($urandom);
      b.wdata = 8'($urandom);
      b.addr = 12'($urandom);
      pick = $urandom_range(0, 9);
      b.keys = (pick < 3) ? 16'd0 : (pick < 6) ? 16'(1 << $urandom_range(0, 15))
                                                : 16'($urandom);
      pick = $urandom_range(0, 99);
      b.kind = (pick < 70) ? REQ_EXEC : (pick < 84) ? REQ_WRITE : (pick < 92) ? REQ_TICK
                                                                               : REQ_ROW;
      if (b.kind == REQ_WRITE && $urandom_range(0, 1))
         b.addr = ireg + 12'($urandom_range(0, 20));
      if (b.kind == REQ_ROW && $urandom_range(0, 4) != 0) b.addr = 12'($urandom_range(0, 31));
      case (b.op[15:12])
         4'h0: begin
            pick = $urandom_range(0, 4);
            if (pick < 2) b.op = OP_CLS;
            else if (pick < 4) b.op = OP_RET;
         end
         4'h5, 4'h9: if ($urandom_range(0, 4) != 0) b.op[3:0] = 4'h0;
         4'h8: if ($urandom_range(0, 6) != 0) b.op[3:0] = alu_codes[$urandom_range(0, 8)];
         4'hE: if ($urandom_range(0, 6) != 0) b.op[7:0] = $urandom_range(0, 1) ? FN_SKP
                                                                                : FN_SKNP;
         4'hF: if ($urandom_range(0, 9) != 0) b.op[7:0] = f_codes[$urandom_range(0, 12)];
         default: ;
      endcase
      return b;
   endfunction

   // Drives one beat: an optional idle gap, then tvalid held until the core takes it.
   task automatic feed_beat(chip_beat_type b, bit typed, chip_result_type typed_res);
      chip_result_type r;
      int           gap;
      int           hole;
      hole = undefined_read(b);
      if (hole == -2) begin
         b.op = {4'h2, b.op[11:0]};  // turn the return into a call, so a later pop has something to return
      end else if (hole >= 0) begin
         b.kind = REQ_WRITE;
         b.addr = 12'(hole);
      end
      r = chip_predict(b);
      pending_results.push_back(typed ? typed_res : r);
      gap = quiet_sender ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= b.kind;
      req_tdata <= {4'd0, b.wdata, b.addr, b.keys, b.rnd, b.op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Directed table, then random traffic.
   initial begin
      chip_beat_type   dir_beats [$];
      bit              dir_typed [$];
      chip_result_type dir_res [$];
      chip_result_type none;
      none = '{pc: 12'd0, row: 64'd0, bad: 1'b0, snd: 1'b0, wt: 1'b0};
      foreach (vreg[i]) vreg[i] = '0;
      foreach (screen[i]) screen[i] = '0;
      ireg = '0;
      pcreg = 12'h200;
      sp = '0;
      dtimer = '0;
      stimer = '0;

      // Reads and housekeeping right after reset have obvious answers.
      dir_beats = '{mk_beat(REQ_ROW, 16'h0000, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_ROW, 16'hFFFF, 16'hFFFF, 12'd31, 8'hFF),
                    mk_beat(REQ_ROW, 16'h0000, 16'h0000, 12'hFFF, 8'h00),
                    mk_beat(REQ_TICK, 16'h0000, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_WRITE, 16'h0000, 16'h0000, 12'h000, 8'hFF),
                    mk_beat(REQ_WRITE, 16'h0000, 16'h0000, 12'hFFF, 8'h81),
                    mk_beat(REQ_EXEC, 16'hFFFF, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, 16'h0000, 16'h0000, 12'd0, 8'h00),
                    // Register arithmetic at the extremes, flags in both senses.
                    mk_beat(REQ_EXEC, 16'h60FF, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, 16'h6101, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, 16'h8014, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, 16'h8015, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, 16'h8017, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, 16'h8F1E, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, 16'h8F16, 16'h0000, 12'd0, 8'h00),
                    // Sprite straddling the end of ram and both screen edges.
                    mk_beat(REQ_EXEC, 16'hAFFF, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, 16'h62FF, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, 16'hD222, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, 16'hD222, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_ROW, 16'h0000, 16'h0000, 12'd31, 8'h00),
                    // Key wait with and without a key, out-of-range key skip.
                    mk_beat(REQ_EXEC, 16'hF30A, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, 16'hF30A, 16'h8000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, 16'hE29E, 16'hFFFF, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, 16'hF233, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, 16'hF265, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, 16'h2FFE, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, OP_RET, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, 16'hF218, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, 16'hBFFF, 16'h0000, 12'd0, 8'h00),
                    mk_beat(REQ_EXEC, OP_CLS, 16'h0000, 12'd0, 8'h00)};
      foreach (dir_beats[i]) begin
         dir_typed.push_back(i < 8);
         dir_res.push_back(none);
      end
      dir_res[0].pc = 12'h200;
      dir_res[1].pc = 12'h200;
      dir_res[2].pc = 12'h200;
      dir_res[3].pc = 12'h200;
      dir_res[4].pc = 12'h200;
      dir_res[5].pc = 12'h200;
      dir_res[6] = '{pc: 12'h202, row: 64'd0, bad: 1'b1, snd: 1'b0, wt: 1'b0};
      dir_res[7] = '{pc: 12'h204, row: 64'd0, bad: 1'b1, snd: 1'b0, wt: 1'b0};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_beats[i]) feed_beat(dir_beats[i], dir_typed[i], dir_res[i]);
      for (int i = 0; i < 1650; i++) begin
         if (i % 150 == 0) quiet_sender = $urandom_range(0, 2) == 0;
         feed_beat(random_beat(), 1'b0, none);
      end
      req_tvalid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Result side: random stalls, bursts without stalls, and one long hold-off so the
   // core backs up and stops taking requests.
   initial begin
      chip_result_type want, got;
      int              stall;
      @(negedge reset);
      forever begin
         if (beats_seen % 120 == 0) quiet_receiver = $urandom_range(0, 2) == 0;
         stall = (beats_seen == 300) ? 400 : quiet_receiver ? 0 : $urandom_range(0, 18);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got.pc  = rsp_tdata[11:0];
         got.row = rsp_tdata[75:12];
         got.bad = rsp_tdata[76];
         got.snd = rsp_tdata[77];
         got.wt  = rsp_tdata[78];
         beats_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %0d: pc %h", beats_seen, got.pc);
         end else begin
            want = pending_results.pop_front();
            if (got.pc !== want.pc || got.row !== want.row || got.bad !== want.bad ||
                got.snd !== want.snd || got.wt !== want.wt) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat %0d: pc %h/%h row %h/%h bad %b/%b snd %b/%b wait %b/%b",
                           beats_seen, want.pc, got.pc, want.row, got.row, want.bad,
                           got.bad, want.snd, got.snd, want.wt, got.wt);
            end
         end
      end
   end

   // Final check once the last response has drained.
   initial begin
      wait (stimulus_done);
      wait (pending_results.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

endmodule
